// ----- hdl/gdc_pkg.sv -----
`default_nettype none
package gdc_pkg;

	localparam int unsigned YEAR_W    = 14;
	localparam int unsigned MONTH_W   = 4;
	localparam int unsigned DAY_W     = 5;
	localparam int unsigned ELAPSED_W = 22;

	localparam logic [YEAR_W-1:0] BASE_YEAR_RST = 14'd1800;

	// month codes
	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	// floor(x / 100) for x < 25600 as (x * 5243) >> 19
	localparam logic [27:0] DIV100_MUL = 28'd5243;
	// floor(v / 7) for v < 680 as (v * 586) >> 12
	localparam logic [18:0] DIV7_MUL = 19'd586;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_in_t;

	typedef struct packed {
		logic                 date_valid;
		logic                 leap;
		logic [4:0]           month_length;
		logic [2:0]           weekday;
		logic [ELAPSED_W-1:0] elapsed_days;
	} date_out_t;

	// after the divider stage
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               after_start;
		logic [YEAR_W-1:0]  year_diff;
		logic [12:0]        ly_q4;
		logic [5:0]         ly_q400;
		logic [7:0]         ly_q100;
		logic [12:0]        ls_q4;
		logic [5:0]         ls_q400;
		logic [7:0]         ls_q100;
		logic [7:0]         year_q100;
		logic [14:0]        zyear;
		logic [7:0]         zcen;
	} s1_t;

	// after the calendar stage
	typedef struct packed {
		logic              date_valid;
		logic              leap;
		logic [4:0]        month_length;
		logic [8:0]        in_year;
		logic              after_start;
		logic [22:0]       year_days;
		logic [11:0]       leap_diff;
		logic [6:0]        zyoc;
		logic [7:0]        zcen;
		logic [4:0]        zmonth;
		logic [DAY_W-1:0]  day;
	} s2_t;

	// after the sum stage
	typedef struct packed {
		logic        date_valid;
		logic        leap;
		logic [4:0]  month_length;
		logic [23:0] elapsed_p1;
		logic [9:0]  zsum;
	} s3_t;

	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = {13'd0, x} * DIV100_MUL;
		return p[26:19];
	endfunction

	// days of months 1 .. m-1 in a common year
	function automatic logic [8:0] month_prefix(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		unique case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			4'd13:   r = 9'd365;
			4'd14:   r = 9'd396;
			default: r = 9'd427;
		endcase
		return r;
	endfunction

	// (13*mm - 1) / 5 with mm = (m + 9) mod 12 + 1
	function automatic logic [4:0] zeller_month(input logic [MONTH_W-1:0] m);
		logic [4:0] r;
		unique case (m)
			4'd0:    r = 5'd25;
			4'd1:    r = 5'd28;
			4'd2:    r = 5'd31;
			4'd3:    r = 5'd2;
			4'd4:    r = 5'd5;
			4'd5:    r = 5'd7;
			4'd6:    r = 5'd10;
			4'd7:    r = 5'd12;
			4'd8:    r = 5'd15;
			4'd9:    r = 5'd18;
			4'd10:   r = 5'd20;
			4'd11:   r = 5'd23;
			4'd12:   r = 5'd25;
			4'd13:   r = 5'd28;
			4'd14:   r = 5'd31;
			default: r = 5'd2;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic lp);
		logic [4:0] r;
		case (m) inside
			MON_FEB:                          r = lp ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: r = 5'd30;
			default:                          r = 5'd31;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/gdc_div_stage.sv -----
`default_nettype none
module gdc_div_stage (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          vld_in,
	input  wire gdc_pkg::date_in_t             d_in,
	input  wire logic [gdc_pkg::YEAR_W-1:0]    base_year,
	output logic                               vld_s1,
	output gdc_pkg::s1_t                       st_s1
);
	import gdc_pkg::*;

	logic [14:0] yz;
	logic [14:0] sz;
	logic [14:0] y399;
	logic [14:0] s399;
	logic [14:0] y3;
	logic [14:0] s3;
	logic [14:0] zy;
	s1_t         nxt;

	always_comb begin
		yz   = {1'b0, d_in.year};
		sz   = {1'b0, base_year};
		y399 = yz + 15'd399;
		s399 = sz + 15'd399;
		y3   = yz + 15'd3;
		s3   = sz + 15'd3;
		// Zeller year: shifted by a full 400-year cycle, January and February go back one
		zy   = yz + ((d_in.month == MON_JAN || d_in.month == MON_FEB) ? 15'd399 : 15'd400);

		nxt.year        = d_in.year;
		nxt.month       = d_in.month;
		nxt.day         = d_in.day;
		nxt.after_start = d_in.year > base_year;
		nxt.year_diff   = d_in.year - base_year;
		nxt.ly_q4       = y3[14:2];
		nxt.ly_q400     = 6'(div100({2'b00, y399[14:2]}));
		nxt.ly_q100     = div100(yz + 15'd99);
		nxt.ls_q4       = s3[14:2];
		nxt.ls_q400     = 6'(div100({2'b00, s399[14:2]}));
		nxt.ls_q100     = div100(sz + 15'd99);
		nxt.year_q100   = div100(yz);
		nxt.zyear       = zy;
		nxt.zcen        = div100(zy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gdc_cal_stage.sv -----
`default_nettype none
module gdc_cal_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_s1,
	input  wire gdc_pkg::s1_t  st_s1,
	output logic               vld_s2,
	output gdc_pkg::s2_t       st_s2
);
	import gdc_pkg::*;

	logic        cent_year;
	logic        lp;
	logic [4:0]  mlen;
	logic [13:0] leaps_y;
	logic [13:0] leaps_s;
	logic [13:0] leaps_d;
	logic [14:0] zcen100;
	logic [14:0] zyoc_w;
	s2_t         nxt;

	always_comb begin
		cent_year = st_s1.year == 14'({6'd0, st_s1.year_q100} * 14'd100);
		// century years leap only when divisible by 400
		lp        = cent_year ? (st_s1.year_q100[1:0] == 2'b00) : (st_s1.year[1:0] == 2'b00);
		mlen      = month_len(st_s1.month, lp);

		leaps_y   = 14'(st_s1.ly_q4) + 14'(st_s1.ly_q400) - 14'(st_s1.ly_q100);
		leaps_s   = 14'(st_s1.ls_q4) + 14'(st_s1.ls_q400) - 14'(st_s1.ls_q100);
		leaps_d   = leaps_y - leaps_s;

		zcen100   = 15'(st_s1.zcen) * 15'd100;
		zyoc_w    = st_s1.zyear - zcen100;

		nxt.date_valid   = (st_s1.month >= MON_JAN) && (st_s1.month <= MON_DEC) &&
			(st_s1.day != '0) && (st_s1.day <= mlen);
		nxt.leap         = lp;
		nxt.month_length = mlen;
		// day plus earlier months, one above the true count
		nxt.in_year      = 9'(st_s1.day) + month_prefix(st_s1.month) +
			9'(lp && (st_s1.month > MON_FEB));
		nxt.after_start  = st_s1.after_start;
		nxt.year_days    = 23'(st_s1.year_diff) * 23'd365;
		nxt.leap_diff    = leaps_d[11:0];
		nxt.zyoc         = zyoc_w[6:0];
		nxt.zcen         = st_s1.zcen;
		nxt.zmonth       = zeller_month(st_s1.month);
		nxt.day          = st_s1.day;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s2 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gdc_sum_stage.sv -----
`default_nettype none
module gdc_sum_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_s2,
	input  wire gdc_pkg::s2_t  st_s2,
	output logic               vld_s3,
	output gdc_pkg::s3_t       st_s3
);
	import gdc_pkg::*;

	logic [23:0] full_years;
	s3_t         nxt;

	always_comb begin
		// years before the start year add nothing
		full_years = st_s2.after_start ?
			(24'(st_s2.year_days) + 24'(st_s2.leap_diff)) : 24'd0;

		nxt.date_valid   = st_s2.date_valid;
		nxt.leap         = st_s2.leap;
		nxt.month_length = st_s2.month_length;
		nxt.elapsed_p1   = full_years + 24'(st_s2.in_year);
		// bias by 336 (a multiple of 7) so the sum stays non-negative
		nxt.zsum         = 10'(st_s2.zmonth) + 10'(st_s2.day) + 10'(st_s2.zyoc) +
			10'(st_s2.zyoc[6:2]) + 10'(st_s2.zcen[7:2]) + 10'd336 - {1'b0, st_s2.zcen, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s3 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gdc_out_stage.sv -----
`default_nettype none
module gdc_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_s3,
	input  wire gdc_pkg::s3_t  st_s3,
	output logic               vld_s4,
	output gdc_pkg::date_out_t st_s4
);
	import gdc_pkg::*;

	localparam logic [23:0] ELAPSED_CAP_P1 = 24'd4194304;

	logic [18:0] q7_prod;
	logic [9:0]  q7x7;
	logic [9:0]  rem7;
	logic [23:0] el_m1;
	date_out_t   nxt;

	always_comb begin
		q7_prod = 19'(st_s3.zsum) * DIV7_MUL;
		q7x7    = 10'(q7_prod[18:12]) * 10'd7;
		rem7    = st_s3.zsum - q7x7;
		el_m1   = st_s3.elapsed_p1 - 24'd1;

		nxt.date_valid   = st_s3.date_valid;
		nxt.leap         = st_s3.leap;
		nxt.month_length = st_s3.month_length;
		nxt.weekday      = rem7[2:0];
		// saturate at both ends
		if (st_s3.elapsed_p1 == 24'd0) begin
			nxt.elapsed_days = '0;
		end else if (st_s3.elapsed_p1 > ELAPSED_CAP_P1) begin
			nxt.elapsed_days = '1;
		end else begin
			nxt.elapsed_days = el_m1[ELAPSED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s4 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gregorian_date_calculator_unit.sv -----
`default_nettype none
// Channel    Direction  Handshake              Payload
// request    in         req_valid / req_ready  req (year, month, day)
// response   out        rsp_valid / rsp_ready  rsp (date_valid, leap, month_length,
//                                                  weekday, elapsed_days)
// config     in         cfg_we                 cfg_wdata (epoch year)
//
// One item per cycle while rsp_ready stays high; rsp_valid follows the accepting edge through
// the four register stages (divide, calendar, sum, output), the first loaded there.
// Reset clears the stage valid bits and loads the epoch year with 1800.
// A stage advances when it is empty or the stage after it advances, so bubbles
// collapse and a stalled response holds every full stage in place.
module gregorian_date_calculator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire gdc_pkg::date_in_t           req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output gdc_pkg::date_out_t               rsp,
	input  wire logic                        cfg_we,
	input  wire logic [gdc_pkg::YEAR_W-1:0]  cfg_wdata
);
	import gdc_pkg::*;

	logic [YEAR_W-1:0] base_year_q;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic en1;
	logic en2;
	logic en3;
	logic en4;

	s1_t       st_s1;
	s2_t       st_s2;
	s3_t       st_s3;
	date_out_t st_s4;

	// Hold the epoch year; the user must write it only while no item is in flight (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year_q <= BASE_YEAR_RST;
		end else if (cfg_we) begin
			base_year_q <= cfg_wdata;
		end
	end

	// Advance a stage when it is empty or its successor advances.
	always_comb begin
		en4 = !vld_s4 || rsp_ready;
		en3 = !vld_s3 || en4;
		en2 = !vld_s2 || en3;
		en1 = !vld_s1 || en2;
	end

	assign req_ready = en1;
	assign rsp_valid = vld_s4;
	assign rsp       = st_s4;

	// Stage 1: constant divisions for leap counts and Zeller century.
	gdc_div_stage u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en1),
		.vld_in     (req_valid),
		.d_in       (req),
		.base_year  (base_year_q),
		.vld_s1     (vld_s1),
		.st_s1      (st_s1)
	);

	// Stage 2: leap flag, month length, validity, year-day product.
	gdc_cal_stage u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en2),
		.vld_s1 (vld_s1),
		.st_s1  (st_s1),
		.vld_s2 (vld_s2),
		.st_s2  (st_s2)
	);

	// Stage 3: elapsed-day sum and Zeller sum.
	gdc_sum_stage u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en3),
		.vld_s2 (vld_s2),
		.st_s2  (st_s2),
		.vld_s3 (vld_s3),
		.st_s3  (st_s3)
	);

	// Stage 4: weekday remainder, saturation, output register.
	gdc_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en4),
		.vld_s3 (vld_s3),
		.st_s3  (st_s3),
		.vld_s4 (vld_s4),
		.st_s4  (st_s4)
	);

	// A draining output never blocks the input.
	a_ready_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("request stalled while response drains");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.weekday != 3'd7))
		else $error("weekday out of range");

	a_feb29_leap: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.month_length == 5'd29)) |-> rsp.leap)
		else $error("29-day month in a common year");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.month_length >= 5'd28))
		else $error("month length below 28");

	// A stalled response holds every full stage: a full sum stage stays full.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && vld_s4 && !rsp_ready) |=> vld_s3)
		else $error("full stage dropped during stall");

endmodule
`default_nettype wire
